/* rtl/nibble_pair_bin_hash_top_defines.svh */
// assertion macros for the nibble pair bin hash checker
// needs a clock named aclk and an active-low reset named aresetn in scope
`ifndef NIBBLE_PAIR_BIN_HASH_TOP_DEFINES_SVH
`define NIBBLE_PAIR_BIN_HASH_TOP_DEFINES_SVH

// same-cycle implication
`define NPBH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("npbh assertion failed");

// next-cycle implication
`define NPBH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("npbh assertion failed");

`endif

/* rtl/npbh_pkg.sv */
// shared constants for the nibble pair bin hash
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package npbh_pkg;

    localparam int NUM_BINS      = 32;
    localparam int TABLE_ENTRIES = 256;

    localparam int BYTE_W       = 8;
    localparam int TBL_ADDR_W   = $clog2(TABLE_ENTRIES);
    localparam int BIN_IDX_W    = $clog2(NUM_BINS);
    localparam int BIN_SUM_W    = 5;
    localparam int BIN_INDEX_W  = 6;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 16;

    localparam logic KIND_TABLE = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

endpackage

`default_nettype wire

/* rtl/nibble_pair_bin_hash_top.sv */
// nibble pair bin hash: table-driven byte-pair digest with stream ports
// depends on npbh_pkg
`timescale 1ns / 1ps
`default_nettype none

// Load the 256-entry byte table with table-write transfers (s_tuser = 0) before any message
// byte reads it. Message bytes (s_tuser = 1) are paired; each pair reads the table once
// and adds the entry into one of the NUM_BINS digest bins through a single registered
// read-modify-write path. A table write or an unpaired byte is taken in ST_IDLE; a pair
// reads the table when accepted and updates its bin in ST_ACCUM. A byte with s_tlast set
// starts the digest: NUM_BINS result transfers, one per cycle when m_tready stays high,
// during which no input is taken. The bins are clear again after the last result is loaded.
module nibble_pair_bin_hash_top (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [npbh_pkg::S_TDATA_W-1:0]    s_tdata,   // table_index, table_value, data_byte
    input  wire                               s_tuser,   // kind
    input  wire                               s_tlast,   // is_last
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [npbh_pkg::M_TDATA_W-1:0]    m_tdata,   // bin_index, bin_value, zero pad
    output logic                              m_tlast    // last_bin
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_EMIT
    } state_t;

    state_t                                state_reg;
    logic [npbh_pkg::BYTE_W-1:0]           held_byte_reg;
    logic                                  held_valid_reg;
    logic [npbh_pkg::BIN_SUM_W-1:0]        bin_reg;
    logic                                  last_pend_reg;
    logic [npbh_pkg::BIN_IDX_W-1:0]        emit_cnt_reg;
    logic [npbh_pkg::BYTE_W-1:0]           bins_reg [npbh_pkg::NUM_BINS];
    logic                                  m_tvalid_reg;
    logic [npbh_pkg::BIN_INDEX_W-1:0]      m_bin_index_reg;
    logic [npbh_pkg::BYTE_W-1:0]           m_bin_value_reg;
    logic                                  m_last_reg;

    logic [npbh_pkg::BYTE_W-1:0]           pair_table [npbh_pkg::TABLE_ENTRIES];
    logic [npbh_pkg::BYTE_W-1:0]           tbl_rd_reg;

    logic [npbh_pkg::BYTE_W-1:0]           tbl_index;
    logic [npbh_pkg::BYTE_W-1:0]           tbl_value;
    logic [npbh_pkg::BYTE_W-1:0]           data_byte;
    logic [npbh_pkg::BYTE_W-1:0]           first_byte;
    logic [npbh_pkg::BYTE_W-1:0]           second_byte;
    logic [npbh_pkg::TBL_ADDR_W-1:0]       rd_addr;
    logic [npbh_pkg::BIN_SUM_W-1:0]        bin_next;
    logic                                  s_accept;
    logic                                  tbl_wr;
    logic                                  emit_load;
    logic                                  emit_done;

    assign tbl_index = s_tdata[7:0];
    assign tbl_value = s_tdata[15:8];
    assign data_byte = s_tdata[23:16];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign tbl_wr    = s_accept && (s_tuser == npbh_pkg::KIND_TABLE);

    // odd final byte pairs with zero
    assign first_byte  = held_valid_reg ? held_byte_reg : data_byte;
    assign second_byte = held_valid_reg ? data_byte : '0;
    assign rd_addr     = {first_byte[7:4], second_byte[7:4]};
    assign bin_next    = npbh_pkg::BIN_SUM_W'(first_byte[3:0]) +
                         npbh_pkg::BIN_SUM_W'(second_byte[3:0]);

    assign emit_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign emit_done = (emit_cnt_reg == npbh_pkg::BIN_IDX_W'(npbh_pkg::NUM_BINS - 1));

    // table memory, registered read
    always_ff @(posedge aclk) begin
        if (tbl_wr) begin
            pair_table[tbl_index] <= tbl_value;
        end
        tbl_rd_reg <= pair_table[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            last_pend_reg  <= 1'b0;
            emit_cnt_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < npbh_pkg::NUM_BINS; i++) begin
                bins_reg[i] <= '0;
            end
        end else begin
            if (m_tvalid_reg && m_tready && !emit_load) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (s_tuser == npbh_pkg::KIND_DATA)) begin
                        if (held_valid_reg || s_tlast) begin
                            held_valid_reg <= 1'b0;
                            held_byte_reg  <= '0;
                            bin_reg        <= bin_next;
                            last_pend_reg  <= s_tlast;
                            state_reg      <= ST_ACCUM;
                        end else begin
                            held_byte_reg  <= data_byte;
                            held_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_ACCUM: begin
                    if (int'(bin_reg) < npbh_pkg::NUM_BINS) begin
                        bins_reg[npbh_pkg::BIN_IDX_W'(bin_reg)] <=
                            bins_reg[npbh_pkg::BIN_IDX_W'(bin_reg)] + tbl_rd_reg;
                    end
                    emit_cnt_reg <= '0;
                    state_reg    <= last_pend_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        m_tvalid_reg           <= 1'b1;
                        m_bin_index_reg        <= npbh_pkg::BIN_INDEX_W'(emit_cnt_reg);
                        m_bin_value_reg        <= bins_reg[emit_cnt_reg];
                        m_last_reg             <= emit_done;
                        bins_reg[emit_cnt_reg] <= '0;
                        if (emit_done) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            emit_cnt_reg <= emit_cnt_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_bin_value_reg, m_bin_index_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

/* rtl/npbh_checker.sv */
// port-level checker for nibble_pair_bin_hash_top, bound to the top level
// depends on npbh_pkg and nibble_pair_bin_hash_top_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "nibble_pair_bin_hash_top_defines.svh"

module npbh_checker (
    input wire                               aclk,
    input wire                               aresetn,
    input wire                               s_tvalid,
    input wire                               s_tready,
    input wire [npbh_pkg::S_TDATA_W-1:0]     s_tdata,
    input wire                               s_tuser,
    input wire                               s_tlast,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [npbh_pkg::M_TDATA_W-1:0]     m_tdata,
    input wire                               m_tlast
);

    // stalled result holds
    `NPBH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // final bin carries the top index
    `NPBH_ASSERT_NOW(a_last_index, m_tvalid && m_tlast,
        m_tdata[5:0] == npbh_pkg::BIN_INDEX_W'(npbh_pkg::NUM_BINS - 1))

    // bins leave in order
    `NPBH_ASSERT_NEXT(a_index_step, m_tvalid && m_tready && !m_tlast,
        !m_tvalid || (m_tdata[5:0] == $past(m_tdata[5:0]) + 6'd1))

    // no input taken mid-digest
    `NPBH_ASSERT_NOW(a_busy_emit, m_tvalid && !m_tlast, !s_tready)

endmodule

bind nibble_pair_bin_hash_top npbh_checker u_npbh_checker (.*);

`default_nettype wire

/* test/nibble_pair_bin_hash_top_tb.sv */
// self-checking testbench for nibble_pair_bin_hash_top: loads the pair table, runs directed
// and random messages with bursty input and a stalling receiver, checks every digest bin
// depends on npbh_pkg and nibble_pair_bin_hash_top
`timescale 1ns / 1ps

module nibble_pair_bin_hash_top_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 220;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 50;

    typedef struct {
        bit       kind;
        bit [7:0] tidx;
        bit [7:0] tval;
        bit [7:0] dbyte;
        bit       last;
    } hash_item_t;

    typedef struct {
        bit [5:0] idx;
        bit [7:0] val;
        bit       last;
    } bin_result_t;

    typedef struct {
        hash_item_t item;
        bit         typed;
        int         tbin;
        bit [7:0]   tvalue;
    } dir_row_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_CADENCE} rx_mode_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [npbh_pkg::S_TDATA_W-1:0] s_tdata;    // table_index, table_value, data_byte
    logic                           s_tuser;    // kind
    logic                           s_tlast;    // is_last
    logic                           m_tvalid;
    logic                           m_tready;
    logic [npbh_pkg::M_TDATA_W-1:0] m_tdata;    // bin_index, bin_value, zero pad
    logic                           m_tlast;    // last_bin

    bit [7:0]    pair_tbl [npbh_pkg::TABLE_ENTRIES];
    bit [7:0]    bin_acc [npbh_pkg::NUM_BINS];
    bit [7:0]    pend_byte;
    bit          pend_valid;
    bin_result_t digest_q [$];
    dir_row_t    dir_q [$];
    bin_result_t want;

    int errors      = 0;
    int cycle_cnt   = 0;
    int sent_cnt    = 0;
    int msg_cnt     = 0;
    int bins_seen   = 0;
    int burst_left  = 1;
    bit hold_req    = 1'b0;

    nibble_pair_bin_hash_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic accumulate_pair(input bit [7:0] first, input bit [7:0] second);
        bit [7:0] addr;
        int       bin;
        addr = {first[7:4], second[7:4]};
        bin  = int'(first[3:0]) + int'(second[3:0]);
        if (bin < npbh_pkg::NUM_BINS) begin
            bin_acc[bin] = bin_acc[bin] + pair_tbl[addr];
        end
    endtask

    // typed rows replace the computed bins: one bin holds tvalue, the rest are zero
    task automatic predict_digest(input hash_item_t it, input bit typed, input int tbin,
                                  input bit [7:0] tvalue);
        bin_result_t r;
        if (it.kind == npbh_pkg::KIND_TABLE) begin
            pair_tbl[it.tidx] = it.tval;
            return;
        end
        if (pend_valid) begin
            accumulate_pair(pend_byte, it.dbyte);
            pend_valid = 1'b0;
            pend_byte  = 8'h00;
        end else if (it.last) begin
            accumulate_pair(it.dbyte, 8'h00);
        end else begin
            pend_byte  = it.dbyte;
            pend_valid = 1'b1;
        end
        if (!it.last) begin
            return;
        end
        for (int k = 0; k < npbh_pkg::NUM_BINS; k++) begin
            r.idx  = 6'(k);
            r.val  = typed ? ((k == tbin) ? tvalue : 8'h00) : bin_acc[k];
            r.last = (k == npbh_pkg::NUM_BINS - 1);
            digest_q.push_back(r);
            bin_acc[k] = 8'h00;
        end
        pend_byte  = 8'h00;
        pend_valid = 1'b0;
        msg_cnt++;
    endtask

    task automatic send_item(input hash_item_t it, input bit typed = 1'b0, input int tbin = 0,
                             input bit [7:0] tvalue = 8'h00);
        int gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = it.kind;
        s_tlast  = it.last;
        s_tdata  = {it.dbyte, it.tval, it.tidx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_cnt++;
        predict_digest(it, typed, tbin, tvalue);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 8);
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic add_row(input bit kind, input bit [7:0] tidx, input bit [7:0] tval,
                           input bit [7:0] dbyte, input bit last, input bit typed = 1'b0,
                           input int tbin = 0, input bit [7:0] tvalue = 8'h00);
        dir_row_t row;
        row.item.kind  = kind;
        row.item.tidx  = tidx;
        row.item.tval  = tval;
        row.item.dbyte = dbyte;
        row.item.last  = last;
        row.typed      = typed;
        row.tbin       = tbin;
        row.tvalue     = tvalue;
        dir_q.push_back(row);
    endtask

    function automatic hash_item_t random_item(input bit kind, input bit last);
        hash_item_t it;
        it.kind  = kind;
        it.tidx  = 8'($urandom);
        it.tval  = 8'($urandom);
        it.dbyte = 8'($urandom);
        it.last  = last;
        return it;
    endfunction

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d bins still expected",
                     $time, cycle_cnt, digest_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            bins_seen++;
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected transfer, bin_index %0d bin_value 0x%02h last %0b",
                         $time, m_tdata[5:0], m_tdata[13:6], m_tlast);
                errors++;
            end else begin
                want = digest_q.pop_front();
                if (m_tdata[5:0] !== want.idx) begin
                    $display("%0t: bin_index expected %0d actual %0d",
                             $time, want.idx, m_tdata[5:0]);
                    errors++;
                end
                if (m_tdata[13:6] !== want.val) begin
                    $display("%0t: bin_value of bin %0d expected 0x%02h actual 0x%02h",
                             $time, want.idx, want.val, m_tdata[13:6]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_bin of bin %0d expected %0b actual %0b",
                             $time, want.idx, want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin : rx_pace
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       phase;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        m_tready  = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            phase++;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:    m_tready = 1'b1;
                    RX_COIN:    m_tready = 1'($urandom_range(0, 1));
                    RX_CADENCE: m_tready = (phase % 4) != 3;
                    default:    m_tready = 1'b1;
                endcase
            end
        end
    end

    initial begin : stimulus
        hash_item_t it;
        int         rand_start;
        int         pick;
        int         len;
        bit         paused;
        paused   = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        for (int i = 0; i < npbh_pkg::NUM_BINS; i++) bin_acc[i] = 8'h00;
        pend_byte  = 8'h00;
        pend_valid = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // every table entry is written before any data byte reads it
        for (int i = 0; i < npbh_pkg::TABLE_ENTRIES; i++) begin
            it      = random_item(npbh_pkg::KIND_TABLE, 1'($urandom_range(0, 1)));
            it.tidx = 8'(i);
            send_item(it);
        end

        add_row(npbh_pkg::KIND_TABLE, 8'h00, 8'hFF, 8'hA5, 1'b0);
        add_row(npbh_pkg::KIND_TABLE, 8'hFF, 8'h01, 8'h5A, 1'b1);
        add_row(npbh_pkg::KIND_TABLE, 8'hF0, 8'h80, 8'hFF, 1'b0);
        add_row(npbh_pkg::KIND_DATA,  8'h3C, 8'hC3, 8'h00, 1'b1, 1'b1, 0,  8'hFF);
        add_row(npbh_pkg::KIND_DATA,  8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_row(npbh_pkg::KIND_DATA,  8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 30, 8'h01);
        // odd final byte pairs with zero
        add_row(npbh_pkg::KIND_DATA,  8'h55, 8'hAA, 8'hFF, 1'b1, 1'b1, 15, 8'h80);
        // table write inside a message keeps the pending byte, is_last ignored
        add_row(npbh_pkg::KIND_DATA,  8'h12, 8'h34, 8'h0F, 1'b0);
        add_row(npbh_pkg::KIND_TABLE, 8'h00, 8'h7F, 8'hEE, 1'b1);
        add_row(npbh_pkg::KIND_DATA,  8'h00, 8'h00, 8'h0F, 1'b1, 1'b1, 30, 8'h7F);
        add_row(npbh_pkg::KIND_DATA,  8'h01, 8'h02, 8'h12, 1'b0);
        add_row(npbh_pkg::KIND_DATA,  8'h03, 8'h04, 8'h34, 1'b0);
        add_row(npbh_pkg::KIND_DATA,  8'h05, 8'h06, 8'h56, 1'b0);
        add_row(npbh_pkg::KIND_DATA,  8'h07, 8'h08, 8'h78, 1'b1);
        add_row(npbh_pkg::KIND_DATA,  8'h09, 8'h0A, 8'hA5, 1'b0);
        add_row(npbh_pkg::KIND_DATA,  8'h0B, 8'h0C, 8'h5A, 1'b0);
        add_row(npbh_pkg::KIND_DATA,  8'h0D, 8'h0E, 8'hC3, 1'b1);
        // bin wraps modulo 256
        add_row(npbh_pkg::KIND_TABLE, 8'h00, 8'hFF, 8'h11, 1'b0);
        add_row(npbh_pkg::KIND_DATA,  8'hFF, 8'h00, 8'h00, 1'b0);
        add_row(npbh_pkg::KIND_DATA,  8'h00, 8'hFF, 8'h00, 1'b0);
        add_row(npbh_pkg::KIND_DATA,  8'hAA, 8'h55, 8'h00, 1'b0);
        add_row(npbh_pkg::KIND_DATA,  8'h55, 8'hAA, 8'h00, 1'b1, 1'b1, 0,  8'hFE);
        foreach (dir_q[i]) begin
            send_item(dir_q[i].item, dir_q[i].typed, dir_q[i].tbin, dir_q[i].tvalue);
        end

        hold_req   = 1'b1;
        rand_start = sent_cnt;
        while (sent_cnt - rand_start < RANDOM_ITEMS) begin
            if (!paused && (sent_cnt - rand_start > RANDOM_ITEMS / 2)) begin
                paused = 1'b1;
                @(negedge aclk);
                s_tvalid = 1'b0;
                wait (digest_q.size() == 0);
            end
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(random_item(npbh_pkg::KIND_TABLE, 1'($urandom_range(0, 1))));
                end
            end else begin
                len = (pick == 3) ? $urandom_range(30, 60) : $urandom_range(1, 10);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        send_item(random_item(npbh_pkg::KIND_TABLE,
                                              1'($urandom_range(0, 1))));
                    end
                    send_item(random_item(npbh_pkg::KIND_DATA, i == len - 1));
                end
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (digest_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d input transfers, %0d digests, %0d bin transfers checked",
                 sent_cnt, msg_cnt, bins_seen);
        $display("with bursty input, receiver stalls and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* nibble_pair_bin_hash_top.f */
+incdir+rtl
rtl/npbh_pkg.sv
rtl/nibble_pair_bin_hash_top.sv
rtl/npbh_checker.sv
test/nibble_pair_bin_hash_top_tb.sv
